// ===== rtl/core/pqa_pkg.sv =====
// Shared types and constants for the packet queue admission block.
// Used by the controller, the datapath, the divider and the top level.
// Depends on nothing else.
package pqa_pkg;

	localparam int LEN_W   = 16;
	localparam int BYTE_W  = 24;
	localparam int PROB_W  = 16;
	localparam int PROD_W  = PROB_W + BYTE_W;
	localparam int PKTS_W  = 9;
	localparam int DROP_W  = 32;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int TDATA_OUT_W = 120;

	localparam logic [PROB_W-1:0] SEED_DEFAULT = 16'd44257;

	// Policy modes.
	localparam logic [MODE_W-1:0] MODE_UNLIMITED = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIFO      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RED       = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TOKEN     = 2'd3;

	// Request kinds.
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RED_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RED_PROB    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED    = 3'd5;

	// Admission class found when an enqueue is evaluated.
	typedef enum logic [1:0] {
		CLS_ADMIT,
		CLS_TAIL,
		CLS_DRAW_FIX,
		CLS_DRAW_DIV
	} pqa_cls_t;

	typedef struct packed {
		logic take_item;
		logic eval;
		logic mul;
		logic div_step;
		logic draw;
		logic commit;
	} pqa_cmd_t;

	typedef struct packed {
		logic     func;
		pqa_cls_t cls;
		logic     out_free;
	} pqa_status_t;

	// The first field sits in the highest bits.
	typedef struct packed {
		logic [DROP_W-1:0] early_drop_count;
		logic [DROP_W-1:0] tail_drop_count;
		logic [PKTS_W-1:0] queue_packets;
		logic [BYTE_W-1:0] queue_bytes;
		logic [LEN_W-1:0]  deq_len;
		logic              deq_valid;
		logic              admitted;
	} pqa_result_t;

endpackage

// ===== rtl/core/pqa_div.sv =====
// Restoring divider producing the RED drop probability one quotient bit a cycle.
// Depends on pqa_pkg for the operand widths.
module pqa_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [pqa_pkg::PROD_W-1:0]  num,
	input  logic [pqa_pkg::BYTE_W-1:0]  den,
	output logic [pqa_pkg::PROB_W-1:0]  quot
);
	import pqa_pkg::*;

	logic [BYTE_W-1:0] rem_q;
	logic [PROB_W-1:0] quo_q;
	logic [BYTE_W:0]   shifted;
	logic [BYTE_W:0]   trial;

	// The numerator is below den * 2^16, so its upper part already starts below den.
	assign shifted = {rem_q, quo_q[PROB_W-1]};
	assign trial   = shifted - {1'b0, den};
	assign quot    = quo_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num[PROD_W-1:PROB_W];
			quo_q <= num[PROB_W-1:0];
		end else if (step) begin
			if (shifted >= {1'b0, den}) begin
				rem_q <= trial[BYTE_W-1:0];
				quo_q <= {quo_q[PROB_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[BYTE_W-1:0];
				quo_q <= {quo_q[PROB_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== rtl/core/pqa_dp.sv =====
// Datapath: configuration registers, length store, counters, LFSR and result register.
// Depends on pqa_pkg and instantiates pqa_div.
module pqa_dp #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pqa_pkg::pqa_cmd_t              cmd,
	output pqa_pkg::pqa_status_t           status,
	input  logic                           cfg_valid,
	input  logic [pqa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pqa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           item_func,
	input  logic [pqa_pkg::LEN_W-1:0]      item_len,
	output logic                           res_valid,
	input  logic                           res_ready,
	output pqa_pkg::pqa_result_t           res
);
	import pqa_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [MODE_W-1:0] mode_q;
	logic [BYTE_W-1:0] limit_q;
	logic [BYTE_W-1:0] red_min_q;
	logic [BYTE_W-1:0] red_max_q;
	logic [PROB_W-1:0] red_prob_q;
	logic [PROB_W-1:0] lfsr_q;

	logic              func_q;
	logic [LEN_W-1:0]  len_q;
	pqa_cls_t          cls_q;
	logic [BYTE_W-1:0] diff_q;
	logic [BYTE_W-1:0] den_q;
	logic              drop_q;

	logic [LEN_W-1:0]  store_q [QUEUE_DEPTH];
	logic [LEN_W-1:0]  rd_data_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] bytes_q;
	logic [DROP_W-1:0] tail_q;
	logic [DROP_W-1:0] early_q;

	logic              out_valid_q;
	pqa_result_t       out_q;

	pqa_cls_t          cls_now;
	logic [PROD_W-1:0] product;
	logic [PROB_W-1:0] quot;
	logic [PROB_W-1:0] prob;
	logic              lfsr_fb;

	logic              do_write;
	logic              do_read;
	logic [BYTE_W:0]   sum;
	logic [CNT_W-1:0]  cnt_d;
	logic [BYTE_W-1:0] bytes_d;
	logic [DROP_W-1:0] tail_d;
	logic [DROP_W-1:0] early_d;
	logic              admitted_d;
	logic [LEN_W-1:0]  deq_len_d;
	logic [31:0]       cnt_ext;

	// Admission class from the occupancy before this request.
	always_comb begin
		cls_now = CLS_ADMIT;
		if (cnt_q == CNT_FULL) begin
			cls_now = CLS_TAIL;
		end else begin
			case (mode_q)
				MODE_UNLIMITED: cls_now = CLS_ADMIT;
				MODE_FIFO, MODE_TOKEN: cls_now = (limit_q > bytes_q) ? CLS_ADMIT : CLS_TAIL;
				MODE_RED: begin
					if (red_min_q > bytes_q)
						cls_now = CLS_ADMIT;
					else if (red_max_q > bytes_q)
						cls_now = CLS_DRAW_DIV;
					else if (limit_q > bytes_q)
						cls_now = CLS_DRAW_FIX;
					else
						cls_now = CLS_TAIL;
				end
				default: cls_now = CLS_TAIL;
			endcase
		end
	end

	assign status.func     = func_q;
	assign status.cls      = cls_now;
	assign status.out_free = !out_valid_q || res_ready;

	assign product = PROD_W'(red_prob_q) * PROD_W'(diff_q);

	pqa_div u_div (
		.clk  (clk),
		.load (cmd.mul),
		.step (cmd.div_step),
		.num  (product),
		.den  (den_q),
		.quot (quot)
	);

	assign prob    = (cls_q == CLS_DRAW_DIV) ? quot : red_prob_q;
	assign lfsr_fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];

	// Outcome of the request and the state it leaves.
	always_comb begin
		do_write   = 1'b0;
		do_read    = 1'b0;
		admitted_d = 1'b0;
		deq_len_d  = '0;
		cnt_d      = cnt_q;
		bytes_d    = bytes_q;
		tail_d     = tail_q;
		early_d    = early_q;
		sum        = {1'b0, bytes_q} + (BYTE_W + 1)'(len_q);
		if (func_q == FUNC_DEQ) begin
			if (cnt_q != '0) begin
				do_read   = 1'b1;
				deq_len_d = rd_data_q;
				cnt_d     = cnt_q - 1'b1;
				bytes_d   = (bytes_q >= BYTE_W'(rd_data_q)) ?
					bytes_q - BYTE_W'(rd_data_q) : '0;
			end
		end else if (cls_q == CLS_TAIL) begin
			tail_d = tail_q + 1'b1;
		end else if ((cls_q == CLS_DRAW_FIX || cls_q == CLS_DRAW_DIV) && drop_q) begin
			early_d = early_q + 1'b1;
		end else if (sum[BYTE_W]) begin
			tail_d = tail_q + 1'b1;
		end else begin
			do_write   = 1'b1;
			admitted_d = 1'b1;
			cnt_d      = cnt_q + 1'b1;
			bytes_d    = sum[BYTE_W-1:0];
		end
		cnt_ext = 32'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_UNLIMITED;
			limit_q    <= '0;
			red_min_q  <= '0;
			red_max_q  <= '0;
			red_prob_q <= '0;
			lfsr_q     <= SEED_DEFAULT;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_POLICY_MODE: mode_q     <= cfg_data[MODE_W-1:0];
					REG_BYTE_LIMIT:  limit_q    <= cfg_data[BYTE_W-1:0];
					REG_RED_MIN:     red_min_q  <= cfg_data[BYTE_W-1:0];
					REG_RED_MAX:     red_max_q  <= cfg_data[BYTE_W-1:0];
					REG_RED_PROB:    red_prob_q <= cfg_data[PROB_W-1:0];
					REG_RNG_SEED: begin
						// An all-zero LFSR would lock up, so zero loads the default seed.
						lfsr_q <= (cfg_data[PROB_W-1:0] == '0) ?
							SEED_DEFAULT : cfg_data[PROB_W-1:0];
					end
					default: ;
				endcase
			end
			if (cmd.draw)
				lfsr_q <= {lfsr_fb, lfsr_q[PROB_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			cnt_q       <= '0;
			bytes_q     <= '0;
			tail_q      <= '0;
			early_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				cnt_q   <= cnt_d;
				bytes_q <= bytes_d;
				tail_q  <= tail_d;
				early_q <= early_d;
				if (do_write)
					wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				if (do_read)
					rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			func_q <= item_func;
			len_q  <= item_len;
		end
		if (cmd.eval) begin
			cls_q  <= cls_now;
			diff_q <= bytes_q - red_min_q;
			den_q  <= red_max_q - red_min_q;
			drop_q <= 1'b0;
		end
		if (cmd.draw)
			drop_q <= lfsr_q < prob;
		if (cmd.commit) begin
			out_q.admitted         <= admitted_d;
			out_q.deq_valid        <= do_read;
			out_q.deq_len          <= deq_len_d;
			out_q.queue_bytes      <= bytes_d;
			out_q.queue_packets    <= cnt_ext[PKTS_W-1:0];
			out_q.tail_drop_count  <= tail_d;
			out_q.early_drop_count <= early_d;
		end
	end

	// Length store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_write)
			store_q[wr_ptr_q] <= len_q;
		rd_data_q <= store_q[rd_ptr_q];
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== rtl/core/pqa_ctrl.sv =====
// Controller state machine sequencing evaluation, division, draw and commit.
// Depends on pqa_pkg for the command and status structs.
module pqa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  pqa_pkg::pqa_status_t status,
	output pqa_pkg::pqa_cmd_t    cmd
);
	import pqa_pkg::*;

	localparam int STEP_W = $clog2(PROB_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROB_W - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_DRAW   = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (status.func == FUNC_DEQ)
					state_d = ST_COMMIT;
				else if (status.cls == CLS_DRAW_DIV)
					state_d = ST_MUL;
				else if (status.cls == CLS_DRAW_FIX)
					state_d = ST_DRAW;
				else
					state_d = ST_COMMIT;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_LAST)
					state_d = ST_DRAW;
			end
			ST_DRAW: begin
				cmd.draw = 1'b1;
				state_d  = ST_COMMIT;
			end
			ST_COMMIT: begin
				// Wait here while the previous result is still held downstream.
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign item_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

endmodule

// ===== rtl/core/packet_queue_admission_red.sv =====
// Top level of the packet descriptor queue with RED admission control.
// Depends on pqa_pkg, pqa_ctrl and pqa_dp.
//
// Each request on the s_ stream either offers a packet length for enqueue
// (s_tuser = 0) or dequeues the oldest stored length (s_tuser = 1). Every
// request yields exactly one result on the m_ stream carrying the verdict,
// the dequeued length and the occupancy and drop counters after the request.
// The cfg_ channel writes the policy registers and is always ready; the user
// must write it only while no request is in flight; the block does not check.
// One request is handled at a time. A dequeue, or an enqueue that needs no
// random draw, goes from evaluation straight to commit, where its result is
// registered. A draw against the fixed probability adds a draw state. In the
// RED ramp region the drop probability comes from a 16-step restoring divider,
// so a multiply state, the divider steps and the draw come before the commit;
// that divider sets the worst-case rate. The next request is taken in the
// cycle after a commit, so no request is accepted before the last commits.
// A finished result waits in the output register while the next request is
// accepted and worked on; that request holds before its commit until m_tready
// has taken the earlier result. Reset empties the queue, clears the counters
// and policy registers and loads the default LFSR seed.
module packet_queue_admission_red #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pqa_pkg::LEN_W-1:0]           s_tdata,  // pkt_len
	input  logic                                s_tuser,  // func
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// admitted, deq_valid, deq_len, queue_bytes, queue_packets,
	// tail_drop_count, early_drop_count, then zero padding
	output logic [pqa_pkg::TDATA_OUT_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pqa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pqa_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pqa_pkg::*;

	localparam int PAD_W = TDATA_OUT_W - $bits(pqa_result_t);

	pqa_cmd_t    cmd;
	pqa_status_t status;
	pqa_result_t res;

	assign cfg_ready = 1'b1;

	pqa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.status     (status),
		.cmd        (cmd)
	);

	pqa_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_func (s_tuser),
		.item_len  (s_tdata),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {{PAD_W{1'b0}}, res};

endmodule
